FILE: rtl/zfla_pkg.sv
// Package for the zone file line assembler.
// Holds character codes, widths, the status code type and the result word struct.
// No dependencies.
`default_nettype none

package zfla_pkg;

    localparam int LINE_LIMIT = 1024;
    localparam int LEN_W = $clog2(LINE_LIMIT + 1);
    localparam int NL_W = 24;

    localparam logic [LEN_W-1:0] LIMIT_V = LEN_W'(LINE_LIMIT);
    localparam logic [NL_W-1:0] NL_MAX = {NL_W{1'b1}};

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_MISSING_CLOSE = 2'd1,
        STATUS_MISSING_OPEN = 2'd2
    } status_t;

    typedef struct packed {
        logic has_char;
        logic [7:0] char_out;
        logic line_end;
        logic [LEN_W-1:0] line_length;
        status_t status;
        logic input_exhausted;
        logic [NL_W-1:0] newline_count;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/zfla_line_core.sv
// Line state and per-byte update of the zone file line assembler.
// Produces at most one result word per accepted input word; uses zfla_pkg.
`default_nettype none

module zfla_line_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      byte_in,
    input  wire logic            end_of_input,
    output logic                 res_valid,
    output zfla_pkg::result_t    res
);
    import zfla_pkg::*;

    logic             quotes_reg, quotes_next;
    logic [LEN_W-1:0] depth_reg, depth_next;
    logic             comment_reg, comment_next;
    logic [7:0]       prev_reg, prev_next;
    logic [LEN_W-1:0] pending_reg, pending_next;
    logic [LEN_W-1:0] iter_reg, iter_next;
    logic [NL_W-1:0]  nl_reg, nl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quotes_reg  <= 1'b0;
            depth_reg   <= '0;
            comment_reg <= 1'b0;
            prev_reg    <= '0;
            pending_reg <= '0;
            iter_reg    <= '0;
            nl_reg      <= '0;
        end
        else if (accept)
        begin
            quotes_reg  <= quotes_next;
            depth_reg   <= depth_next;
            comment_reg <= comment_next;
            prev_reg    <= prev_next;
            pending_reg <= pending_next;
            iter_reg    <= iter_next;
            nl_reg      <= nl_next;
        end
    end

    always_comb
    begin
        logic             esc;
        logic             has;
        logic [7:0]       ch;
        logic             ends;
        status_t          st;
        logic             quotes_w;
        logic [LEN_W-1:0] depth_w;
        logic             comment_w;
        logic [LEN_W-1:0] pend_w;
        logic [LEN_W-1:0] iter_w;

        quotes_next  = quotes_reg;
        depth_next   = depth_reg;
        comment_next = comment_reg;
        prev_next    = prev_reg;
        pending_next = pending_reg;
        iter_next    = iter_reg;
        nl_next      = nl_reg;
        res_valid    = 1'b0;
        res          = '0;

        esc       = (prev_reg == CH_BSLASH);
        has       = 1'b0;
        ch        = '0;
        ends      = 1'b0;
        st        = STATUS_OK;
        quotes_w  = quotes_reg;
        depth_w   = depth_reg;
        comment_w = comment_reg;
        pend_w    = pending_reg;
        iter_w    = iter_reg;

        if (!end_of_input && byte_in == CH_NEWLINE && nl_reg != NL_MAX)
        begin
            nl_next = nl_reg + 1'b1;
        end
        res.newline_count = nl_next;

        if (end_of_input)
        begin
            res_valid  = 1'b1;
            res.status = (depth_reg != '0) ? STATUS_MISSING_CLOSE : STATUS_OK;
            if (pending_reg != '0)
            begin
                res.line_end    = 1'b1;
                res.line_length = pending_reg;
            end
            else
            begin
                res.input_exhausted = 1'b1;
            end
            quotes_next  = 1'b0;
            depth_next   = '0;
            comment_next = 1'b0;
            prev_next    = '0;
            pending_next = '0;
            iter_next    = '0;
        end
        else if (!(comment_reg && byte_in != CH_NEWLINE))
        begin
            if (byte_in == CH_QUOTE && !esc)
            begin
                quotes_w = ~quotes_reg;
                has      = 1'b1;
                ch       = byte_in;
            end
            else if (byte_in == CH_LPAREN)
            begin
                has = 1'b1;
                if (!quotes_reg && !esc)
                begin
                    depth_w = depth_reg + 1'b1;
                    ch      = CH_SPACE;
                end
                else
                begin
                    ch = byte_in;
                end
            end
            else if (byte_in == CH_RPAREN)
            begin
                if (!quotes_reg && !esc)
                begin
                    if (depth_reg == '0)
                    begin
                        ends = 1'b1;
                        st   = STATUS_MISSING_OPEN;
                    end
                    else
                    begin
                        depth_w = depth_reg - 1'b1;
                        has     = 1'b1;
                        ch      = CH_SPACE;
                    end
                end
                else
                begin
                    has = 1'b1;
                    ch  = byte_in;
                end
            end
            else if (byte_in == CH_SEMI && !esc)
            begin
                comment_w = 1'b1;
            end
            else if (byte_in == CH_NEWLINE && !esc)
            begin
                comment_w = 1'b0;
                if (depth_reg == '0)
                begin
                    ends = 1'b1;
                end
            end
            else
            begin
                has = 1'b1;
                ch  = byte_in;
            end

            pend_w = pending_reg + LEN_W'(has);

            if (!ends)
            begin
                iter_w = iter_reg + 1'b1;
                if (iter_w >= LIMIT_V)
                begin
                    ends = 1'b1;
                    st   = (depth_w != '0) ? STATUS_MISSING_CLOSE : STATUS_OK;
                end
            end

            if (ends)
            begin
                res_valid       = 1'b1;
                res.has_char    = has;
                res.char_out    = ch;
                res.line_end    = 1'b1;
                res.line_length = pend_w;
                res.status      = st;
                quotes_next     = 1'b0;
                depth_next      = '0;
                comment_next    = 1'b0;
                prev_next       = '0;
                pending_next    = '0;
                iter_next       = '0;
            end
            else
            begin
                res_valid    = has;
                res.has_char = has;
                res.char_out = ch;
                quotes_next  = quotes_w;
                depth_next   = depth_w;
                comment_next = comment_w;
                prev_next    = byte_in;
                pending_next = pend_w;
                iter_next    = iter_w;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/zone_file_line_assembler_top.sv
// Top level of the zone file line assembler.
// Holds the line core and a two-entry output buffer; uses zfla_pkg and zfla_line_core.
//
// The input channel carries one word per cycle while in_stall is low: a text byte,
// or an end of input mark when end_of_input is high. Each accepted word gives zero
// or one result word on the output channel: a line byte (has_char), the end of a
// logical line (line_end with line_length and status), or an empty end of input
// (input_exhausted). newline_count rides on every result word.
// A result is registered at the edge that accepts its input word, into the output
// register when that is free and else into the skid register. The line state update
// is a single level of compares and counter steps ahead of the output register.
// When the receiver stalls, the output register holds its word and one more
// result goes into a skid register; while that skid register is full, in_stall
// is high. Reset clears the line state, the newline counter and the valid flags
// of both output registers; in_stall is low right after reset.
`default_nettype none

module zone_file_line_assembler_top (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [7:0]               byte_in,
    input  wire logic                     end_of_input,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          has_char,
    output logic [7:0]                    char_out,
    output logic                          line_end,
    output logic [zfla_pkg::LEN_W-1:0]    line_length,
    output logic [1:0]                    status,
    output logic                          input_exhausted,
    output logic [zfla_pkg::NL_W-1:0]     newline_count
);
    import zfla_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    zfla_line_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_in      (byte_in),
        .end_of_input (end_of_input),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && res_valid)
        begin
            if (out_free)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign has_char        = out_reg.has_char;
    assign char_out        = out_reg.char_out;
    assign line_end        = out_reg.line_end;
    assign line_length     = out_reg.line_length;
    assign status          = 2'(out_reg.status);
    assign input_exhausted = out_reg.input_exhausted;
    assign newline_count   = out_reg.newline_count;

endmodule

`default_nettype wire

FILE: rtl/zfla_checker.sv
// Port-level checks for the zone file line assembler.
// Depends on zfla_pkg and is bound to zone_file_line_assembler_top.
`default_nettype none

module zfla_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic                     has_char,
    input wire logic [7:0]               char_out,
    input wire logic                     line_end,
    input wire logic [zfla_pkg::LEN_W-1:0] line_length,
    input wire logic [1:0]               status,
    input wire logic                     input_exhausted,
    input wire logic [zfla_pkg::NL_W-1:0] newline_count
);
    import zfla_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out)
            && $stable(line_length) && $stable(newline_count))
        else $error("Stalled output word changed.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
        else $error("Input stalled without a stalled output.");

    a_status_scope: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'(STATUS_OK) |-> line_end || input_exhausted)
        else $error("Status set on a plain line byte.");

    a_length_scope: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_end |-> line_length == '0
            && !(input_exhausted && has_char))
        else $error("Length or byte on a word that does not end a line.");

endmodule

bind zone_file_line_assembler_top zfla_checker u_zfla_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .has_char        (has_char),
    .char_out        (char_out),
    .line_end        (line_end),
    .line_length     (line_length),
    .status          (status),
    .input_exhausted (input_exhausted),
    .newline_count   (newline_count)
);

`default_nettype wire

FILE: sim/zfla_line_checker.sv
`timescale 1ns / 100ps
// Checker for the zone file line assembler: watches both channels, predicts each result
// word from the accepted input words and compares it field by field with the block's output.
// Depends on zfla_pkg.

module zfla_line_checker
    import zfla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [7:0]        byte_in,
    input  wire logic              end_of_input,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic              has_char,
    input  wire logic [7:0]        char_out,
    input  wire logic              line_end,
    input  wire logic [LEN_W-1:0]  line_length,
    input  wire logic [1:0]        status,
    input  wire logic              input_exhausted,
    input  wire logic [NL_W-1:0]   newline_count,
    output int                     error_count,
    output int                     words_pending
);

    logic             in_quotes;
    logic             in_comment;
    logic [LEN_W-1:0] depth;
    logic [LEN_W-1:0] pend_len;
    logic [LEN_W-1:0] iter_cnt;
    logic [7:0]       prev_byte;
    logic [NL_W-1:0]  nl_total;
    result_t          line_words[$];

    initial
    begin
        error_count = 0;
        words_pending = 0;
    end

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic clear_line();
        in_quotes = 1'b0;
        in_comment = 1'b0;
        depth = '0;
        pend_len = '0;
        iter_cnt = '0;
        prev_byte = '0;
    endtask

    task automatic assemble_word(input logic [7:0] b, input logic eoi,
                                 output logic produced, output result_t word);
        logic    esc;
        logic    fin;
        status_t st;
        produced = 1'b0;
        word = '0;
        fin = 1'b0;
        st = STATUS_OK;
        if (eoi)
        begin
            word.status = (depth != 0) ? STATUS_MISSING_CLOSE : STATUS_OK;
            if (pend_len != 0)
            begin
                word.line_end = 1'b1;
                word.line_length = pend_len;
            end
            else
                word.input_exhausted = 1'b1;
            word.newline_count = nl_total;
            produced = 1'b1;
            clear_line();
            return;
        end
        if (b == CH_NEWLINE && nl_total != NL_MAX)
            nl_total++;
        if (in_comment && b != CH_NEWLINE)
            return;
        esc = (prev_byte == CH_BSLASH);
        if (b == CH_QUOTE && !esc)
        begin
            in_quotes = !in_quotes;
            word.has_char = 1'b1;
            word.char_out = b;
        end
        else if (b == CH_LPAREN)
        begin
            word.has_char = 1'b1;
            if (!in_quotes && !esc)
            begin
                depth++;
                word.char_out = CH_SPACE;
            end
            else
                word.char_out = b;
        end
        else if (b == CH_RPAREN)
        begin
            if (!in_quotes && !esc)
            begin
                if (depth == 0)
                begin
                    fin = 1'b1;
                    st = STATUS_MISSING_OPEN;
                end
                else
                begin
                    depth--;
                    word.has_char = 1'b1;
                    word.char_out = CH_SPACE;
                end
            end
            else
            begin
                word.has_char = 1'b1;
                word.char_out = b;
            end
        end
        else if (b == CH_SEMI && !esc)
            in_comment = 1'b1;
        else if (b == CH_NEWLINE && !esc)
        begin
            in_comment = 1'b0;
            if (depth == 0)
                fin = 1'b1;
        end
        else
        begin
            word.has_char = 1'b1;
            word.char_out = b;
        end
        if (word.has_char)
            pend_len++;
        if (!fin)
        begin
            prev_byte = b;
            iter_cnt++;
            if (iter_cnt >= LIMIT_V)
            begin
                fin = 1'b1;
                st = (depth != 0) ? STATUS_MISSING_CLOSE : STATUS_OK;
            end
        end
        if (fin)
        begin
            word.line_end = 1'b1;
            word.line_length = pend_len;
            word.status = st;
            clear_line();
        end
        word.newline_count = nl_total;
        produced = fin || word.has_char;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic    made;
        result_t want;
        result_t next_word;
        if (!rst_n)
        begin
            clear_line();
            nl_total = '0;
            line_words.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (line_words.size() == 0)
                    report_error($sformatf("unexpected result word: char %02h line_end %0b",
                                           char_out, line_end));
                else
                begin
                    want = line_words.pop_front();
                    check_field("has_char", has_char, want.has_char);
                    check_field("char_out", char_out, want.char_out);
                    check_field("line_end", line_end, want.line_end);
                    check_field("line_length", line_length, want.line_length);
                    check_field("status", status, want.status);
                    check_field("input_exhausted", input_exhausted, want.input_exhausted);
                    check_field("newline_count", newline_count, want.newline_count);
                end
            end
            if (in_valid && !in_stall)
            begin
                assemble_word(byte_in, end_of_input, made, next_word);
                if (made)
                    line_words.push_back(next_word);
            end
        end
        words_pending = line_words.size();
    end

endmodule

FILE: sim/zone_file_line_assembler_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the zone file line assembler: clock, reset, input and output traffic
// and the verdict. Depends on zfla_pkg, zone_file_line_assembler_top and zfla_line_checker.

module zone_file_line_assembler_top_tb;
    import zfla_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_WORDS = 410;
    localparam int LONG_HOLD = 300;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [7:0]        byte_in = '0;
    logic              end_of_input = 1'b0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic              has_char;
    logic [7:0]        char_out;
    logic              line_end;
    logic [LEN_W-1:0]  line_length;
    logic [1:0]        status;
    logic              input_exhausted;
    logic [NL_W-1:0]   newline_count;
    int                error_count;
    int                words_pending;
    int                words_sent = 0;
    int                idle_cycles = 0;
    logic              tx_quiet = 1'b0;
    logic              rx_quiet = 1'b0;
    logic              long_hold_req = 1'b0;

    zone_file_line_assembler_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .end_of_input    (end_of_input),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .has_char        (has_char),
        .char_out        (char_out),
        .line_end        (line_end),
        .line_length     (line_length),
        .status          (status),
        .input_exhausted (input_exhausted),
        .newline_count   (newline_count)
    );

    zfla_line_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .end_of_input    (end_of_input),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .has_char        (has_char),
        .char_out        (char_out),
        .line_end        (line_end),
        .line_length     (line_length),
        .status          (status),
        .input_exhausted (input_exhausted),
        .newline_count   (newline_count),
        .error_count     (error_count),
        .words_pending   (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("zone_file_line_assembler_top_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : receiver
        int n;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                n = LONG_HOLD;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
                n = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eoi);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= b;
        end_of_input <= eoi;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 6))
            0: return CH_QUOTE;
            1: return CH_LPAREN;
            2: return CH_RPAREN;
            3: return CH_SEMI;
            4: return CH_BSLASH;
            5: return CH_NEWLINE;
            default: return "a" + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic send_random_line();
        int   tokens;
        int   opened;
        logic done;
        tokens = $urandom_range(1, 10);
        opened = 0;
        done = 1'b0;
        for (int t = 0; t < tokens && !done; t++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:
                    repeat ($urandom_range(1, 6))
                        send_word("a" + 8'($urandom_range(0, 25)), 1'b0);
                6, 7:
                    send_word(CH_SPACE, 1'b0);
                8, 9:
                begin
                    send_word(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 4))
                        send_word(pick_special(), 1'b0);
                    send_word(CH_QUOTE, 1'b0);
                end
                10, 11:
                begin
                    send_word(CH_LPAREN, 1'b0);
                    opened++;
                end
                12, 13:
                begin
                    if (opened > 0)
                    begin
                        send_word(CH_RPAREN, 1'b0);
                        opened--;
                    end
                    else
                        send_word(CH_SPACE, 1'b0);
                end
                14:
                    send_word(CH_NEWLINE, 1'b0);
                15:
                begin
                    send_word(CH_BSLASH, 1'b0);
                    send_word(pick_special(), 1'b0);
                end
                16:
                begin
                    send_word(CH_SEMI, 1'b0);
                    repeat ($urandom_range(0, 5))
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                    done = 1'b1;
                end
                17:
                    send_word(8'($urandom_range(0, 255)), 1'b0);
                18:
                    send_word(8'($urandom_range(0, 255)), 1'b1);
                default:
                    send_word(CH_RPAREN, 1'b0);
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            repeat (opened) send_word(CH_RPAREN, 1'b0);
        send_word(CH_NEWLINE, 1'b0);
    endtask

    initial
    begin : stimulus
        int random_start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(8'($urandom_range(0, 255)), 1'b1);
        send_text(")");
        send_text("(a\n)\n");
        send_text("\\\n\n");
        send_text("\"(;)\"\n");
        send_text("x;");
        send_word(8'hFF, 1'b0);
        send_text("(\n");
        send_text("\\\"\\(\\)\\;x\n");
        send_text("(");
        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(CH_LPAREN, 1'b0);

        long_hold_req = 1'b1;
        tx_quiet = 1'b1;
        random_start = words_sent;
        while (words_sent < random_start + RANDOM_WORDS)
            send_random_line();

        in_valid <= 1'b0;
        @(posedge clk);
        wait (words_pending == 0);
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("zone_file_line_assembler_top_tb: clean");
        else
            $display("zone_file_line_assembler_top_tb: errors");
        $finish;
    end

endmodule
